// ===== hdl/cft_pkg.sv =====
// cft_pkg: shared types and constants for the channel feature tracker.
// Sample and result transfer structs, lane control bundle, sequencer states.
// No dependencies.
package cft_pkg;

  localparam int CHANNELS_MAX = 4;
  localparam int LINES_MAX    = 8;
  localparam int VAL_W        = 16;
  localparam int SUM_W        = 32;
  localparam int LEVEL_W      = 8;
  localparam int DIV_STEPS    = VAL_W;  // quotient always fits in VAL_W bits
  localparam int STEP_W       = $clog2(DIV_STEPS);

  localparam logic [VAL_W-1:0] COUNT_FULL = 16'hFFFF;

  typedef struct packed {
    logic               first;
    logic [VAL_W-1:0]   reading_a;
    logic [VAL_W-1:0]   reading_b;
    logic [VAL_W-1:0]   reading_c;
    logic [VAL_W-1:0]   reading_d;
    logic [LEVEL_W-1:0] level_word;
  } sample_t;

  typedef struct packed {
    logic [63:0]        minima_packed;
    logic [63:0]        maxima_packed;
    logic [63:0]        means_packed;
    logic [63:0]        spreads_packed;
    logic [63:0]        toggles_low;
    logic [63:0]        toggles_high;
    logic [LEVEL_W-1:0] level_now;
    logic [VAL_W-1:0]   samples_seen;
  } result_t;

  typedef struct packed {
    logic take;   // sample transfer: update min/max/sum
    logic first;  // restart statistics with this sample
    logic room;   // count not yet full, sum may grow
    logic load;   // load divider from sum and count
    logic step;   // one divider iteration
  } lane_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/cft_lane.sv =====
// cft_lane: statistics for one analog channel plus a bit-serial mean divider.
// Keeps running min, max and sum; divides sum by count one bit a cycle.
// Depends on cft_pkg.
module cft_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  cft_pkg::lane_ctrl_t           ctrl,
  input  logic [cft_pkg::VAL_W-1:0]     reading,
  input  logic [cft_pkg::VAL_W-1:0]     count,
  output logic [cft_pkg::VAL_W-1:0]     min_val,
  output logic [cft_pkg::VAL_W-1:0]     max_val,
  output logic [cft_pkg::VAL_W-1:0]     mean_val,
  output logic [cft_pkg::VAL_W-1:0]     spread_val
);

  logic [cft_pkg::SUM_W-1:0] sum;
  logic [cft_pkg::VAL_W-1:0] rem;
  logic [cft_pkg::VAL_W-1:0] quo;
  logic [cft_pkg::VAL_W-1:0] dvsr;
  logic [cft_pkg::VAL_W:0]   trial;
  logic                      ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_val <= cft_pkg::COUNT_FULL;
      max_val <= '0;
      sum     <= '0;
    end else if (ctrl.take) begin
      if (ctrl.first) begin
        min_val <= reading;
        max_val <= reading;
        sum     <= {{(cft_pkg::SUM_W-cft_pkg::VAL_W){1'b0}}, reading};
      end else begin
        if (reading < min_val) min_val <= reading;
        if (reading > max_val) max_val <= reading;
        if (ctrl.room) sum <= sum + {{(cft_pkg::SUM_W-cft_pkg::VAL_W){1'b0}}, reading};
      end
    end
  end

  // restoring divide; sum < count * 2^16, so the upper half starts below the divisor
  assign trial = {rem, quo[cft_pkg::VAL_W-1]};
  assign ge    = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem  <= sum[cft_pkg::SUM_W-1:cft_pkg::VAL_W];
      quo  <= sum[cft_pkg::VAL_W-1:0];
      dvsr <= count;
    end else if (ctrl.step) begin
      rem  <= ge ? cft_pkg::VAL_W'(trial - {1'b0, dvsr}) : trial[cft_pkg::VAL_W-1:0];
      quo  <= {quo[cft_pkg::VAL_W-2:0], ge};
    end
  end

  assign mean_val   = quo;
  assign spread_val = (max_val >= min_val) ? (max_val - min_val) : '0;

endmodule

// ===== hdl/cft_toggle.sv =====
// cft_toggle: per-line toggle counters and the last level word.
// Saturating counts; a first sample clears them and counts nothing.
// Depends on cft_pkg.
module cft_toggle #(
  parameter int LINES = cft_pkg::LINES_MAX
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               take,
  input  logic                                               first,
  input  logic [cft_pkg::LEVEL_W-1:0]                        level,
  output logic [cft_pkg::LINES_MAX-1:0][cft_pkg::VAL_W-1:0]  counts,
  output logic [cft_pkg::LEVEL_W-1:0]                        level_last
);

  logic [LINES-1:0][cft_pkg::VAL_W-1:0] cnt;
  logic [cft_pkg::LEVEL_W-1:0]          diff;

  assign diff = level ^ level_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_last <= '0;
      cnt        <= '0;
    end else if (take) begin
      level_last <= level;
      for (int k = 0; k < LINES; k++) begin
        if (first) begin
          cnt[k] <= '0;
        end else if (diff[k] && cnt[k] != cft_pkg::COUNT_FULL) begin
          cnt[k] <= cnt[k] + 1'b1;
        end
      end
    end
  end

  for (genvar k = 0; k < cft_pkg::LINES_MAX; k++) begin : g_slot
    if (k < LINES) begin : g_used
      assign counts[k] = cnt[k];
    end else begin : g_unused
      assign counts[k] = '0;
    end
  end

endmodule

// ===== hdl/channel_feature_tracker_core.sv =====
// channel_feature_tracker_core: top level of the channel feature tracker.
// Sequencer, sample counter, analog lanes, toggle counters, result register.
// Depends on cft_pkg, cft_lane, cft_toggle.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+-------------------
//   sample   | in        | sample_valid / sample_stall  | cft_pkg::sample_t
//   result   | out       | result_valid / result_stall  | cft_pkg::result_t
//
// Per sample: the idle cycle that takes the transfer updates min/max/sum,
// ST_LOAD loads the dividers, ST_DIV runs the shift-subtract divide for the
// means (one quotient bit per cycle per lane) and ST_DONE writes the result.
// The lanes divide in parallel, so the sequence does not lengthen with channels.
// sample_stall is high from the cycle after the transfer until the result is
// written. Reset (rst, synchronous) restores min to all ones and max, sum,
// counts, state and result_valid to 0; divider and result data are not reset.
// A stalled result sits in the result register while the next sample runs;
// the sequencer only waits in its last state while that register is full and stalled.
module channel_feature_tracker_core #(
  parameter int ANALOG_CHANNELS = cft_pkg::CHANNELS_MAX,
  parameter int DIGITAL_LINES   = cft_pkg::LINES_MAX
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  cft_pkg::sample_t  sample,
  output logic              result_valid,
  input  logic              result_stall,
  output cft_pkg::result_t  result
);

  cft_pkg::state_t                   state, state_next;
  logic [cft_pkg::STEP_W-1:0]        step_cnt;
  logic [cft_pkg::VAL_W-1:0]         total;
  logic                              take;
  logic                              room;
  logic                              result_load;
  cft_pkg::lane_ctrl_t               lane_ctrl;

  logic [cft_pkg::CHANNELS_MAX-1:0][cft_pkg::VAL_W-1:0] readings;
  logic [cft_pkg::CHANNELS_MAX-1:0][cft_pkg::VAL_W-1:0] mins, maxs, means, spreads;
  logic [cft_pkg::LINES_MAX-1:0][cft_pkg::VAL_W-1:0]    toggles;
  logic [cft_pkg::LEVEL_W-1:0]                          level_last;

  // --- sample transfer and counter ---
  assign sample_stall = (state != cft_pkg::ST_IDLE);
  assign take         = sample_valid && !sample_stall;
  // a first sample restarts the count, so there is always room for it
  assign room         = sample.first || (total != cft_pkg::COUNT_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (take) begin
      if (sample.first) total <= cft_pkg::VAL_W'(1);
      else if (room)    total <= total + 1'b1;
    end
  end

  // --- sequencer ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cft_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == cft_pkg::ST_DIV) step_cnt <= step_cnt + 1'b1;
      else                          step_cnt <= '0;
    end
  end

  always_comb begin
    state_next  = state;
    result_load = 1'b0;
    unique case (state)
      cft_pkg::ST_IDLE: begin
        if (take) state_next = cft_pkg::ST_LOAD;
      end
      cft_pkg::ST_LOAD: begin
        state_next = cft_pkg::ST_DIV;
      end
      cft_pkg::ST_DIV: begin
        if (step_cnt == cft_pkg::STEP_W'(cft_pkg::DIV_STEPS - 1)) state_next = cft_pkg::ST_DONE;
      end
      cft_pkg::ST_DONE: begin
        // write only when the result register is free or draining now
        if (!result_valid || !result_stall) begin
          result_load = 1'b1;
          state_next  = cft_pkg::ST_IDLE;
        end
      end
      default: state_next = cft_pkg::ST_IDLE;
    endcase
  end

  assign lane_ctrl.take  = take;
  assign lane_ctrl.first = sample.first;
  assign lane_ctrl.room  = room;
  assign lane_ctrl.load  = (state == cft_pkg::ST_LOAD);
  assign lane_ctrl.step  = (state == cft_pkg::ST_DIV);

  // --- analog lanes ---
  assign readings[0] = sample.reading_a;
  assign readings[1] = sample.reading_b;
  assign readings[2] = sample.reading_c;
  assign readings[3] = sample.reading_d;

  for (genvar k = 0; k < cft_pkg::CHANNELS_MAX; k++) begin : g_lane
    if (k < ANALOG_CHANNELS) begin : g_used
      cft_lane u_lane (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (lane_ctrl),
        .reading    (readings[k]),
        .count      (total),
        .min_val    (mins[k]),
        .max_val    (maxs[k]),
        .mean_val   (means[k]),
        .spread_val (spreads[k])
      );
    end else begin : g_unused
      // channel not built: its slots read as zero
      assign mins[k]    = '0;
      assign maxs[k]    = '0;
      assign means[k]   = '0;
      assign spreads[k] = '0;
    end
  end

  // --- digital lines ---
  cft_toggle #(
    .LINES (DIGITAL_LINES)
  ) u_toggle (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .first      (sample.first),
    .level      (sample.level_word),
    .counts     (toggles),
    .level_last (level_last)
  );

  // --- merge into the result register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.minima_packed  <= mins;
      result.maxima_packed  <= maxs;
      result.means_packed   <= means;
      result.spreads_packed <= spreads;
      result.toggles_low    <= toggles[3:0];
      result.toggles_high   <= toggles[7:4];
      result.level_now      <= level_last;
      result.samples_seen   <= total;
    end
  end

`ifndef NO_ASSERTIONS
  // a transfer always starts the divider load next cycle
  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    take |=> state == cft_pkg::ST_LOAD)
    else $error("sample transfer did not start the divider load");

  // the divide runs exactly its step count before the result stage
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == cft_pkg::ST_DIV && step_cnt == cft_pkg::STEP_W'(cft_pkg::DIV_STEPS - 1))
      |=> state == cft_pkg::ST_DONE)
    else $error("divider did not finish after its last step");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !result_load)
    else $error("result register written while a result was pending");

  // every delivered result counts at least its own sample
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.samples_seen != '0)
    else $error("result reports zero samples");
`endif

endmodule

// ===== dv/cft_stats_checker.sv =====
// cft_stats_checker: watches the sample and result channels of the channel
// feature tracker, predicts every result and compares it field by field.
// Depends on cft_pkg.
module cft_stats_checker #(
  parameter int ANALOG_CHANNELS = cft_pkg::CHANNELS_MAX,
  parameter int DIGITAL_LINES   = cft_pkg::LINES_MAX
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  logic             sample_stall,
  input  cft_pkg::sample_t sample,
  input  logic             result_valid,
  input  logic             result_stall,
  input  cft_pkg::result_t result,
  output int               errors,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [cft_pkg::VAL_W-1:0]   lo_val   [cft_pkg::CHANNELS_MAX];
  logic [cft_pkg::VAL_W-1:0]   hi_val   [cft_pkg::CHANNELS_MAX];
  logic [cft_pkg::SUM_W-1:0]   acc      [cft_pkg::CHANNELS_MAX];
  logic [cft_pkg::VAL_W-1:0]   edges    [cft_pkg::LINES_MAX];
  logic [cft_pkg::LEVEL_W-1:0] last_level;
  logic [cft_pkg::VAL_W-1:0]   taken;

  cft_pkg::result_t expected_reports[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic clear_stats();
    for (int k = 0; k < cft_pkg::CHANNELS_MAX; k++) begin
      lo_val[k] = cft_pkg::COUNT_FULL;
      hi_val[k] = '0;
      acc[k]    = '0;
    end
    for (int k = 0; k < cft_pkg::LINES_MAX; k++) edges[k] = '0;
    last_level = '0;
    taken      = '0;
  endtask

  // Updates the running statistics with one sample and builds its report.
  task automatic accumulate_sample(input cft_pkg::sample_t s, output cft_pkg::result_t r);
    logic [cft_pkg::VAL_W-1:0]   rd [cft_pkg::CHANNELS_MAX];
    logic [cft_pkg::LEVEL_W-1:0] diff;
    logic                        room;
    logic [cft_pkg::SUM_W-1:0]   quot;
    logic [cft_pkg::VAL_W-1:0]   spread;
    rd[0] = s.reading_a;
    rd[1] = s.reading_b;
    rd[2] = s.reading_c;
    rd[3] = s.reading_d;
    if (s.first) clear_stats();
    room = (taken != cft_pkg::COUNT_FULL);
    for (int k = 0; k < ANALOG_CHANNELS && k < cft_pkg::CHANNELS_MAX; k++) begin
      if (rd[k] < lo_val[k]) lo_val[k] = rd[k];
      if (rd[k] > hi_val[k]) hi_val[k] = rd[k];
      if (room) acc[k] = acc[k] + {16'd0, rd[k]};
    end
    if (!s.first) begin
      diff = s.level_word ^ last_level;
      for (int k = 0; k < DIGITAL_LINES && k < cft_pkg::LINES_MAX; k++)
        if (diff[k] && edges[k] != cft_pkg::COUNT_FULL) edges[k] = edges[k] + 1'b1;
    end
    last_level = s.level_word;
    if (room) taken = taken + 1'b1;

    r = '0;
    for (int k = 0; k < ANALOG_CHANNELS && k < cft_pkg::CHANNELS_MAX; k++) begin
      quot   = (taken != 0) ? acc[k] / {16'd0, taken} : '0;
      spread = (hi_val[k] >= lo_val[k]) ? hi_val[k] - lo_val[k] : '0;
      r.minima_packed[16*k +: 16]  = lo_val[k];
      r.maxima_packed[16*k +: 16]  = hi_val[k];
      r.means_packed[16*k +: 16]   = quot[15:0];
      r.spreads_packed[16*k +: 16] = spread;
    end
    for (int k = 0; k < DIGITAL_LINES && k < cft_pkg::LINES_MAX; k++) begin
      if (k < 4) r.toggles_low[16*k +: 16] = edges[k];
      else       r.toggles_high[16*(k-4) +: 16] = edges[k];
    end
    r.level_now    = s.level_word;
    r.samples_seen = taken;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cft_pkg::result_t want;
    if (rst) begin
      clear_stats();
      expected_reports.delete();
    end else begin
      if (sample_valid && !sample_stall) begin
        accumulate_sample(sample, want);
        expected_reports.push_back(want);
      end
      if (result_valid && !result_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with no sample pending");
          errors++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("minima_packed",  want.minima_packed,  result.minima_packed);
          compare_field("maxima_packed",  want.maxima_packed,  result.maxima_packed);
          compare_field("means_packed",   want.means_packed,   result.means_packed);
          compare_field("spreads_packed", want.spreads_packed, result.spreads_packed);
          compare_field("toggles_low",    want.toggles_low,    result.toggles_low);
          compare_field("toggles_high",   want.toggles_high,   result.toggles_high);
          compare_field("level_now",      64'(want.level_now),    64'(result.level_now));
          compare_field("samples_seen",   64'(want.samples_seen), 64'(result.samples_seen));
        end
      end
    end
    outstanding = expected_reports.size();
  end

endmodule

// ===== dv/channel_feature_tracker_core_test.sv =====
// channel_feature_tracker_core_test: stimulus and verdict for the tracker.
// Drives sample transfers and result back-pressure; checking is done by
// cft_stats_checker. Depends on cft_pkg, cft_stats_checker and the core.
module channel_feature_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // No transfer on either channel for this many cycles means the block hung.
  // A correct run rarely goes quiet for longer than one sample's sequence
  // plus a sender gap plus a result stall.
  localparam int WATCHDOG_LIMIT = 2000;
  // Final stretch with no idling on either side.
  localparam int SOAK_ITEMS     = 200;
  localparam int RANDOM_ITEMS   = 1500;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             sample_valid = 1'b0;
  logic             sample_stall;
  cft_pkg::sample_t sample = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  cft_pkg::result_t result;

  int errors;
  int outstanding;
  int quiet = 0;
  int hold_left = 0;
  bit idle_on = 1'b1;   // random idling on both sides

  always #5 clk = ~clk;

  channel_feature_tracker_core DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  cft_stats_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
        quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Result back-pressure: stall bursts of random length starting at
  // random, so they land on every phase of the block's sequence.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 9);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic cft_pkg::sample_t make_sample(input bit f, input logic [15:0] a,
                                                   input logic [15:0] b,
                                                   input logic [15:0] c,
                                                   input logic [15:0] d,
                                                   input logic [7:0] lv);
    cft_pkg::sample_t s;
    s.first      = f;
    s.reading_a  = a;
    s.reading_b  = b;
    s.reading_c  = c;
    s.reading_d  = d;
    s.level_word = lv;
    return s;
  endfunction

  // Readings biased toward the ends of the range and small values, so that
  // min/max updates, narrow spreads and small means all show up.
  function automatic logic [15:0] pick_reading();
    case ($urandom_range(0, 6))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 15));
      3:       return 16'($urandom_range(16'hFFF0, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_level(input logic [7:0] prev);
    case ($urandom_range(0, 4))
      0:       return prev;
      1:       return prev ^ (8'h01 << $urandom_range(0, 7));
      2:       return ~prev;
      default: return 8'($urandom);
    endcase
  endfunction

  // One sample transfer. An optional gap comes first: either straight after
  // the previous transfer (inside the block's busy window) or once the
  // block has dropped its stall.
  task automatic send_sample(input cft_pkg::sample_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk) sample_valid <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        @(posedge clk);
        while (sample_stall) @(posedge clk);
      end
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Sender holds off until every expected result has come back.
  task automatic drain();
    @(negedge clk) sample_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0] lv;
    int         batch_left;
    bit         f;

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: start without a clear (toggles against level 0), range
    // extremes, clears back to back, a clear mid-stream.
    send_sample(make_sample(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'hFF));
    send_sample(make_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00));
    send_sample(make_sample(1'b0, 16'h8000, 16'h0001, 16'hFFFE, 16'h7FFF, 8'hA5));
    send_sample(make_sample(1'b0, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE, 8'h5A));
    send_sample(make_sample(1'b1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 8'h5A));
    send_sample(make_sample(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 8'hFF));
    send_sample(make_sample(1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h00));
    send_sample(make_sample(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 8'h01));
    send_sample(make_sample(1'b0, 16'h0007, 16'h0003, 16'hFFF8, 16'h0100, 8'h80));
    send_sample(make_sample(1'b0, 16'h0007, 16'h0003, 16'hFFF8, 16'h0100, 8'h80));
    send_sample(make_sample(1'b1, 16'h0005, 16'h0005, 16'h0005, 16'h0005, 8'hFF));
    send_sample(make_sample(1'b0, 16'h0005, 16'h0005, 16'h0005, 16'h0005, 8'hFF));
    send_sample(make_sample(1'b0, 16'h0006, 16'h0004, 16'hFFFF, 16'h0000, 8'h00));
    send_sample(make_sample(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA));
    send_sample(make_sample(1'b0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55));
    send_sample(make_sample(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    lv = 8'h00;

    // Random: mostly batches opened by a clear, some carried on without one,
    // with idling switched off now and then for a stretch.
    batch_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) idle_on <= ($urandom_range(0, 3) != 0);
      if (i == RANDOM_ITEMS / 2) drain();
      f = 1'b0;
      if (batch_left == 0) begin
        batch_left = $urandom_range(1, 60);
        f = ($urandom_range(0, 7) != 0);
      end else if ($urandom_range(0, 49) == 0) begin
        f = 1'b1;
      end
      batch_left--;
      lv = pick_level(lv);
      send_sample(make_sample(f, pick_reading(), pick_reading(), pick_reading(),
                              pick_reading(), lv));
    end

    // Last stretch, no idling: one batch with every line toggling each
    // sample, samples back to back.
    idle_on <= 1'b0;
    drain();
    lv = 8'h3C;
    send_sample(make_sample(1'b1, pick_reading(), pick_reading(), pick_reading(),
                            pick_reading(), lv));
    for (int i = 0; i < SOAK_ITEMS; i++) begin
      lv = ~lv;
      send_sample(make_sample(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), lv));
    end
    // Clear, then carry on a few samples.
    for (int i = 0; i < 6; i++) begin
      lv = pick_level(lv);
      send_sample(make_sample(i == 0, pick_reading(), pick_reading(), pick_reading(),
                              pick_reading(), lv));
    end

    drain();
    repeat (40) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
